@@ rtl/plp_pkg.sv @@
// Package for the positional insert/delete list.
// Holds field widths, the request kind codes and the sequencer states; no dependencies.
package plp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  // Request kinds carried in the kind field.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_REM_RD,
    ST_REM_WR,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

endpackage

@@ rtl/plp_if.sv @@
// Handshake interfaces for the request and result channels of the list.
// Depends on plp_pkg for the field widths.
interface plp_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [plp_pkg::PosW-1:0]     position;
  logic signed [plp_pkg::DataW-1:0] new_value;

  modport source (output valid, kind, position, new_value, input ready);
  modport sink   (input valid, kind, position, new_value, output ready);
endinterface

interface plp_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [plp_pkg::DataW-1:0] read_value;
  logic [plp_pkg::CountW-1:0]       entry_count;
  logic                             is_empty;
  logic                             insert_dropped;
  logic                             read_out_of_range;

  modport source (output valid, read_value, entry_count, is_empty, insert_dropped,
                  read_out_of_range, input ready);
  modport sink   (input valid, read_value, entry_count, is_empty, insert_dropped,
                  read_out_of_range, output ready);
endinterface

@@ rtl/positional_insert_delete_list.sv @@
// Positional insert/delete list, one request at a time.
// Insert at p moves the entries from p up by one, remove at p moves the entries after p
// down by one, one entry at a time through the single memory read port and write port.
// A request is taken only when the last one is done; the result register lets the next
// request in while a result waits.
// Reset clears the count and the control state; the entry memory is not cleared.
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plp_req_if.sink     req_i,
  plp_rsp_if.source   rsp_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic                      we;
  logic [AddrW-1:0]          waddr;
  logic [plp_pkg::DataW-1:0] wdata;
  logic                      re;
  logic [AddrW-1:0]          raddr;
  logic [plp_pkg::DataW-1:0] rdata;
  logic [plp_pkg::DataW-1:0] read_value;

  // Sequencer and result register.
  plp_seq #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (req_i.valid),
    .req_ready_o         (req_i.ready),
    .kind_i              (req_i.kind),
    .position_i          (req_i.position),
    .new_value_i         (req_i.new_value),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_ready_i         (rsp_o.ready),
    .read_value_o        (read_value),
    .entry_count_o       (rsp_o.entry_count),
    .is_empty_o          (rsp_o.is_empty),
    .insert_dropped_o    (rsp_o.insert_dropped),
    .read_out_of_range_o (rsp_o.read_out_of_range),
    .we_o                (we),
    .waddr_o             (waddr),
    .wdata_o             (wdata),
    .re_o                (re),
    .raddr_o             (raddr),
    .rdata_i             (rdata)
  );

  // Entry memory.
  plp_store #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rsp_o.read_value = read_value;

endmodule

@@ rtl/plp_store.sv @@
// Entry memory of the list: one write port and one read port with registered read data.
// Depends on plp_pkg for the data width.
module plp_store #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned AddrW    = 4
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [plp_pkg::DataW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [plp_pkg::DataW-1:0]   rdata_o
);

  logic [plp_pkg::DataW-1:0] mem_q [Capacity];
  logic [plp_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/plp_seq.sv @@
// Sequencer of the list: walks the shift loops one entry at a time with a shared
// index step unit, keeps the count and holds the result register.
// Depends on plp_pkg.
module plp_seq #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned AddrW    = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request side.
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic [plp_pkg::PosW-1:0]         position_i,
  input  logic [plp_pkg::DataW-1:0]        new_value_i,
  // Result side.
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic [plp_pkg::DataW-1:0]        read_value_o,
  output logic [plp_pkg::CountW-1:0]       entry_count_o,
  output logic                             is_empty_o,
  output logic                             insert_dropped_o,
  output logic                             read_out_of_range_o,
  // Memory port.
  output logic                             we_o,
  output logic [AddrW-1:0]                 waddr_o,
  output logic [plp_pkg::DataW-1:0]        wdata_o,
  output logic                             re_o,
  output logic [AddrW-1:0]                 raddr_o,
  input  logic [plp_pkg::DataW-1:0]        rdata_i
);

  // Common width for comparing positions against the count.
  localparam int unsigned PW = (CntW > plp_pkg::PosW) ? CntW : plp_pkg::PosW;
  // Width for presenting the count on the fixed-width result field.
  localparam int unsigned EW = (CntW > plp_pkg::CountW) ? CntW : plp_pkg::CountW;
  localparam logic [CntW-1:0] CapCount = CntW'(Capacity);

  plp_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovalid_q, ovalid_d;

  logic [CntW-1:0]           idx_q, idx_d;
  logic [PW-1:0]             pos_q, pos_d;
  logic [plp_pkg::DataW-1:0] val_q, val_d;
  logic [plp_pkg::DataW-1:0] rdval_q, rdval_d;
  logic                      drop_q, drop_d;
  logic                      oor_q, oor_d;

  logic [plp_pkg::DataW-1:0] out_val_q;
  logic [EW-1:0]             out_cnt_q;
  logic                      out_empty_q, out_drop_q, out_oor_q;

  logic                      load_out;
  logic                      step_up;
  logic [CntW-1:0]           idx_step;
  logic [PW-1:0]             in_pos;
  logic [PW-1:0]             count_x;
  plp_pkg::kind_e            kind;

  assign in_pos  = PW'(position_i);
  assign count_x = PW'(count_q);
  assign kind    = plp_pkg::kind_e'(kind_i);

  // Shared index unit: one increment or decrement per cycle.
  assign step_up  = (state_q == plp_pkg::ST_REM_RD) || (state_q == plp_pkg::ST_REM_WR);
  assign idx_step = step_up ? (idx_q + CntW'(1)) : (idx_q - CntW'(1));

  assign req_ready_o = (state_q == plp_pkg::ST_IDLE);

  // Next state, memory control and result flags.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    val_d    = val_q;
    rdval_d  = rdval_q;
    drop_d   = drop_q;
    oor_d    = oor_q;
    we_o     = 1'b0;
    waddr_o  = idx_q[AddrW-1:0];
    wdata_o  = rdata_i;
    re_o     = 1'b0;
    raddr_o  = idx_step[AddrW-1:0];
    load_out = 1'b0;

    case (state_q)
      plp_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          rdval_d = '0;
          drop_d  = 1'b0;
          oor_d   = 1'b0;
          pos_d   = in_pos;
          val_d   = new_value_i;
          state_d = plp_pkg::ST_DONE;
          case (kind)
            plp_pkg::KIND_INSERT: begin
              if (count_q == CapCount) begin
                drop_d = 1'b1;
              end else if (in_pos >= count_x) begin
                // Append at the end.
                we_o    = 1'b1;
                waddr_o = count_q[AddrW-1:0];
                wdata_o = new_value_i;
                count_d = count_q + CntW'(1);
              end else begin
                idx_d   = count_q;
                state_d = plp_pkg::ST_INS_RD;
              end
            end
            plp_pkg::KIND_REMOVE: begin
              if (in_pos < count_x) begin
                idx_d   = in_pos[CntW-1:0];
                state_d = plp_pkg::ST_REM_RD;
              end
            end
            plp_pkg::KIND_READ: begin
              if (in_pos < count_x) begin
                re_o    = 1'b1;
                raddr_o = in_pos[AddrW-1:0];
                state_d = plp_pkg::ST_READ_WAIT;
              end else begin
                oor_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Insert: move entry idx-1 up to idx, walking down to the position.
      plp_pkg::ST_INS_RD: begin
        re_o    = 1'b1;
        state_d = plp_pkg::ST_INS_WR;
      end
      plp_pkg::ST_INS_WR: begin
        we_o  = 1'b1;
        idx_d = idx_step;
        if (PW'(idx_step) == pos_q) begin
          state_d = plp_pkg::ST_INS_PUT;
        end else begin
          state_d = plp_pkg::ST_INS_RD;
        end
      end
      plp_pkg::ST_INS_PUT: begin
        we_o    = 1'b1;
        wdata_o = val_q;
        count_d = count_q + CntW'(1);
        state_d = plp_pkg::ST_DONE;
      end
      // Remove: move entry idx+1 down to idx until the last entry.
      plp_pkg::ST_REM_RD: begin
        if (idx_step < count_q) begin
          re_o    = 1'b1;
          state_d = plp_pkg::ST_REM_WR;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = plp_pkg::ST_DONE;
        end
      end
      plp_pkg::ST_REM_WR: begin
        we_o    = 1'b1;
        idx_d   = idx_step;
        state_d = plp_pkg::ST_REM_RD;
      end
      plp_pkg::ST_READ_WAIT: begin
        rdval_d = rdata_i;
        state_d = plp_pkg::ST_DONE;
      end
      plp_pkg::ST_DONE: begin
        if (!ovalid_q || rsp_ready_i) begin
          load_out = 1'b1;
          state_d  = plp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plp_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register valid.
  always_comb begin
    ovalid_d = ovalid_q;
    if (rsp_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (load_out) begin
      ovalid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= plp_pkg::ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    rdval_q <= rdval_d;
    drop_q  <= drop_d;
    oor_q   <= oor_d;
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_val_q   <= rdval_q;
      out_cnt_q   <= EW'(count_q);
      out_empty_q <= (count_q == '0);
      out_drop_q  <= drop_q;
      out_oor_q   <= oor_q;
    end
  end

  assign rsp_valid_o         = ovalid_q;
  assign read_value_o        = out_val_q;
  assign entry_count_o       = out_cnt_q[plp_pkg::CountW-1:0];
  assign is_empty_o          = out_empty_q;
  assign insert_dropped_o    = out_drop_q;
  assign read_out_of_range_o = out_oor_q;

endmodule

@@ tb/positional_insert_delete_list_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the positional insert/delete list.
// Needs plp_pkg, the plp_req_if/plp_rsp_if interfaces and the list RTL; reads no files.
module positional_insert_delete_list_tb;

  localparam int unsigned Capacity   = 16;
  localparam int          RandomReqs = 1800;
  localparam int          PhaseLen   = 60;
  localparam int          DrainWait  = 40;
  localparam int          DirRows    = 17;

  // One result as the list should report it.
  typedef struct {
    logic signed [plp_pkg::DataW-1:0] read_value;
    logic [plp_pkg::CountW-1:0]       entry_count;
    logic                             is_empty;
    logic                             insert_dropped;
    logic                             read_out_of_range;
  } list_rsp_t;

  // One request, optionally carrying a hand-written expectation.
  typedef struct {
    plp_pkg::kind_e                   kind;
    logic [plp_pkg::PosW-1:0]         position;
    logic signed [plp_pkg::DataW-1:0] new_value;
    bit                               typed;
    list_rsp_t                        typed_rsp;
  } list_req_t;

  // Directed row; reps repeats the request with the value stepped by one.
  typedef struct {
    plp_pkg::kind_e                   kind;
    logic [plp_pkg::PosW-1:0]         pos;
    logic signed [plp_pkg::DataW-1:0] val;
    int                               reps;
    bit                               typed;
    logic signed [plp_pkg::DataW-1:0] x_rd;
    logic [plp_pkg::CountW-1:0]       x_cnt;
    bit                               x_empty;
    bit                               x_drop;
    bit                               x_oor;
  } dir_row_t;

  dir_row_t directed_rows [DirRows] = '{
    // kind               pos    value        reps typed rd          cnt   emp   drp   oor
    '{plp_pkg::KIND_READ,   4'd0,  32'sd0,        1, 1'b1, 32'sd0,       5'd0,  1'b1, 1'b0, 1'b1},
    '{plp_pkg::KIND_REMOVE, 4'd5,  32'sd0,        1, 1'b1, 32'sd0,       5'd0,  1'b1, 1'b0, 1'b0},
    '{plp_pkg::KIND_NONE,   4'd15, -32'sd1,       1, 1'b1, 32'sd0,       5'd0,  1'b1, 1'b0, 1'b0},
    '{plp_pkg::KIND_INSERT, 4'd15, 32'h7fffffff,  1, 1'b1, 32'sd0,       5'd1,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_INSERT, 4'd0,  32'h80000000,  1, 1'b1, 32'sd0,       5'd2,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_READ,   4'd0,  32'sd0,        1, 1'b1, 32'h80000000, 5'd2,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_READ,   4'd1,  32'hffffffff,  1, 1'b1, 32'h7fffffff, 5'd2,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_READ,   4'd2,  32'sd0,        1, 1'b1, 32'sd0,       5'd2,  1'b0, 1'b0, 1'b1},
    '{plp_pkg::KIND_INSERT, 4'd1,  32'h00000100, 14, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_INSERT, 4'd0,  32'h12345678,  1, 1'b1, 32'sd0,       5'd16, 1'b0, 1'b1, 1'b0},
    '{plp_pkg::KIND_READ,   4'd15, 32'sd0,        1, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_REMOVE, 4'd0,  32'sd0,        1, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_READ,   4'd0,  32'sd0,        1, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_REMOVE, 4'd15, 32'sd0,        1, 1'b1, 32'sd0,       5'd15, 1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_READ,   4'd15, 32'sd0,        1, 1'b1, 32'sd0,       5'd15, 1'b0, 1'b0, 1'b1},
    '{plp_pkg::KIND_REMOVE, 4'd14, 32'sd0,        1, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0},
    '{plp_pkg::KIND_INSERT, 4'd14, 32'h5555aaaa,  1, 1'b0, 32'sd0,       5'd0,  1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  plp_req_if req_bus ();
  plp_rsp_if rsp_bus ();

  positional_insert_delete_list #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow copy of the list contents and bookkeeping.
  logic signed [plp_pkg::DataW-1:0] model_list [Capacity];
  int unsigned                      model_count;
  list_rsp_t                        pending_results [$];
  list_req_t                        request_queue [$];
  int                               n_req;
  int                               n_rsp;
  int                               n_errors;
  int                               n_dropped;
  int                               n_out_of_range;
  int                               n_full;
  int                               n_emptied;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A generous bound on the whole run.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Both sides take random breaks, except during a quiet stretch mid-run.
  function automatic bit idle_roll();
    if (n_req >= 700 && n_req < 1000) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_rsp_t list_step(input plp_pkg::kind_e kind,
                                          input logic [plp_pkg::PosW-1:0] pos,
                                          input logic signed [plp_pkg::DataW-1:0] value);
    list_rsp_t   rsp;
    int unsigned p;
    rsp.read_value        = '0;
    rsp.insert_dropped    = 1'b0;
    rsp.read_out_of_range = 1'b0;
    p = 32'(pos);
    case (kind)
      plp_pkg::KIND_INSERT: begin
        if (model_count >= Capacity) begin
          rsp.insert_dropped = 1'b1;
          n_dropped++;
        end else begin
          // A position at or past the end appends.
          if (p > model_count) p = model_count;
          for (int unsigned j = model_count; j > p; j--) model_list[j] = model_list[j-1];
          model_list[p] = value;
          model_count++;
          if (model_count == Capacity) n_full++;
        end
      end
      plp_pkg::KIND_REMOVE: begin
        if (p < model_count) begin
          for (int unsigned j = p; j + 1 < model_count; j++) model_list[j] = model_list[j+1];
          model_count--;
          if (model_count == 0) n_emptied++;
        end
      end
      plp_pkg::KIND_READ: begin
        if (p < model_count) begin
          rsp.read_value = model_list[p];
        end else begin
          rsp.read_out_of_range = 1'b1;
          n_out_of_range++;
        end
      end
      default: ;
    endcase
    rsp.entry_count = model_count[plp_pkg::CountW-1:0];
    rsp.is_empty    = (model_count == 0);
    return rsp;
  endfunction

  // Stimulus, request driving and the end of the run.
  initial begin
    list_req_t                        item;
    list_req_t                        cur;
    list_rsp_t                        predicted;
    bit                               holding;
    bit                               fill_phase;
    int                               roll;
    int unsigned                      pick;
    logic signed [plp_pkg::DataW-1:0] corner;

    rst_ni            = 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.kind      <= plp_pkg::KIND_NONE;
    req_bus.position  <= '0;
    req_bus.new_value <= '0;
    model_count       = 0;
    n_req             = 0;
    n_rsp             = 0;
    n_errors          = 0;
    n_dropped         = 0;
    n_out_of_range    = 0;
    n_full            = 0;
    n_emptied         = 0;
    holding           = 1'b0;

    // Expand the directed table.
    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        item.kind                        = directed_rows[i].kind;
        item.position                    = directed_rows[i].pos;
        item.new_value                   = directed_rows[i].val + r;
        item.typed                       = directed_rows[i].typed;
        item.typed_rsp.read_value        = directed_rows[i].x_rd;
        item.typed_rsp.entry_count       = directed_rows[i].x_cnt;
        item.typed_rsp.is_empty          = directed_rows[i].x_empty;
        item.typed_rsp.insert_dropped    = directed_rows[i].x_drop;
        item.typed_rsp.read_out_of_range = directed_rows[i].x_oor;
        request_queue.push_back(item);
      end
    end

    // Random part: phases that lean toward filling and then toward draining the list,
    // with positions skewed low so removes keep hitting live entries.
    item.typed = 1'b0;
    for (int i = 0; i < RandomReqs; i++) begin
      fill_phase = ((i / PhaseLen) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 3) item.kind = plp_pkg::KIND_NONE;
      else if (roll < 25) item.kind = plp_pkg::KIND_READ;
      else if ((roll < 82) == fill_phase) item.kind = plp_pkg::KIND_INSERT;
      else item.kind = plp_pkg::KIND_REMOVE;
      if ($urandom_range(0, 1) == 1) pick = $urandom_range(0, 15);
      else pick = $urandom_range(0, $urandom_range(0, 15));
      item.position = pick[plp_pkg::PosW-1:0];
      case ($urandom_range(0, 3))
        0: corner = 32'h80000000;
        1: corner = 32'h7fffffff;
        2: corner = 32'sd0;
        default: corner = -32'sd1;
      endcase
      item.new_value = ($urandom_range(0, 9) == 0) ? corner : $urandom();
      request_queue.push_back(item);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Present requests; the predictor runs as each one is accepted.
    while (request_queue.size() != 0 || holding) begin
      @(posedge clk_i);
      if (req_bus.valid && req_bus.ready) begin
        predicted = list_step(cur.kind, cur.position, cur.new_value);
        pending_results.push_back(cur.typed ? cur.typed_rsp : predicted);
        n_req++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (request_queue.size() == 0 || idle_roll()) begin
          req_bus.valid <= 1'b0;
        end else begin
          cur = request_queue.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.kind      <= cur.kind;
          req_bus.position  <= cur.position;
          req_bus.new_value <= cur.new_value;
          holding = 1'b1;
        end
      end
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d requests, %0d results checked, %0d mismatches.", n_req, n_rsp, n_errors);
    $display("List filled %0d times and emptied %0d times; %0d inserts dropped, %0d %s",
             n_full, n_emptied, n_dropped, n_out_of_range, "reads out of range.");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin : result_check
    list_rsp_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_rsp++;
        if (pending_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp_bus.read_value);
            n_errors++;
          end
          if (rsp_bus.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_bus.entry_count);
            n_errors++;
          end
          if (rsp_bus.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_bus.is_empty);
            n_errors++;
          end
          if (rsp_bus.insert_dropped !== want.insert_dropped) begin
            $error("insert_dropped: expected %0b, got %0b", want.insert_dropped,
                   rsp_bus.insert_dropped);
            n_errors++;
          end
          if (rsp_bus.read_out_of_range !== want.read_out_of_range) begin
            $error("read_out_of_range: expected %0b, got %0b", want.read_out_of_range,
                   rsp_bus.read_out_of_range);
            n_errors++;
          end
        end
      end
      rsp_bus.ready <= !idle_roll();
    end else begin
      rsp_bus.ready <= 1'b0;
    end
  end

endmodule

@@ positional_insert_delete_list.f @@
rtl/plp_pkg.sv
rtl/plp_if.sv
rtl/plp_store.sv
rtl/plp_seq.sv
rtl/positional_insert_delete_list.sv
tb/positional_insert_delete_list_tb.sv
